>>> rtl/msd_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment driver package
// Types, codes and constants shared by the multiplexed seven-segment driver.
// ----------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

  typedef enum logic [1:0] {
    OP_SCAN  = 2'd0,
    OP_SET   = 2'd1,
    OP_SHOW  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_POL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIG_POL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd2;

  localparam int DIGIT_PINS = 4;
  localparam int BCD_DIGITS = 4;
  localparam int NUM_W      = 14;
  localparam logic [NUM_W-1:0] NUM_MAX = 14'd9999;
  localparam logic [3:0] RADIX = 4'd10;
  localparam logic [7:0] DP_BIT = 8'h80;

  // Reciprocal constants for division by 10, 100 and 1000 of values up to 9999.
  localparam logic [15:0] RECIP_10   = 16'd52429;
  localparam logic [12:0] RECIP_100  = 13'd5243;
  localparam logic [13:0] RECIP_1000 = 14'd8389;

  typedef struct packed {
    opcode_t     opcode;
    logic [2:0]  position;
    logic [3:0]  digit_value;
    logic        decimal_point;
    logic [15:0] number;
  } in_item_t;

  typedef struct packed {
    logic                  status;
    logic [7:0]            segment_levels;
    logic [DIGIT_PINS-1:0] digit_levels;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] value);
    logic [7:0] pat;
    unique case (value)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

  function automatic logic [NUM_W-1:0] pow10(input int k);
    logic [NUM_W-1:0] p;
    unique case (k)
      0:       p = 14'd1;
      1:       p = 14'd10;
      2:       p = 14'd100;
      default: p = 14'd1000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/msd_if.sv
// ----------------------------------------------------------------------------
// Seven-segment driver channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface msd_in_if;
  import msd_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface msd_out_if;
  import msd_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/msd_ctrl.sv
// ----------------------------------------------------------------------------
// Seven-segment driver controller
// Sequences one command at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output msd_pkg::cmd_t    cmd
);
  import msd_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   exec_go;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign cmd.load  = in_ready && in_valid;
  assign cmd.exec  = exec_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        S_EXEC: begin
          if (exec_go) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/msd_datapath.sv
// ----------------------------------------------------------------------------
// Seven-segment driver datapath
// Holds configuration, pattern buffer, scan state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module msd_datapath #(
  parameter int DIGITS = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire msd_pkg::cmd_t                cmd,
  input  wire msd_pkg::in_item_t            in_item,
  input  wire logic                         cfg_we,
  input  wire logic [msd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                         cfg_data,
  output msd_pkg::out_item_t                out_item
);
  import msd_pkg::*;

  localparam int PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  in_item_t         item_r;
  logic [NUM_W-1:0] num_r;
  logic [9:0]       q1_r;
  logic [6:0]       q2_r;
  logic [3:0]       q3_r;

  logic seg_pol_r;
  logic dig_pol_r;
  logic enable_r;

  logic [7:0]        buf_r   [DIGITS];
  logic [7:0]        buf_nxt [DIGITS];
  logic [PW-1:0]     scan_r;
  logic [PW-1:0]     scan_nxt;
  logic [7:0]        lit_seg_r;
  logic [7:0]        lit_seg_nxt;
  logic [DIGITS-1:0] lit_sel_r;
  logic [DIGITS-1:0] lit_sel_nxt;
  out_item_t         out_r;
  out_item_t         out_nxt;

  logic [NUM_W-1:0] sat;
  logic [29:0]      prod10;
  logic [26:0]      prod100;
  logic [27:0]      prod1000;
  logic [3:0]       bcd [BCD_DIGITS];
  logic             set_ok;
  logic [7:0]       seg_src;
  logic [DIGIT_PINS-1:0] dig_lv;

  // Saturation and reciprocal quotients are taken when the command is accepted.
  assign sat = (in_item.number > 16'(NUM_MAX)) ? NUM_MAX : in_item.number[NUM_W-1:0];
  assign prod10   = 30'(sat) * 30'(RECIP_10);
  assign prod100  = 27'(sat) * 27'(RECIP_100);
  assign prod1000 = 28'(sat) * 28'(RECIP_1000);

  assign bcd[0] = 4'(num_r - 14'({q1_r, 3'b000}) - 14'({q1_r, 1'b0}));
  assign bcd[1] = 4'(q1_r - 10'({q2_r, 3'b000}) - 10'({q2_r, 1'b0}));
  assign bcd[2] = 4'(q2_r - 7'({q3_r, 3'b000}) - 7'({q3_r, 1'b0}));
  assign bcd[3] = q3_r;

  assign set_ok = ({1'b0, item_r.position} < 4'(DIGITS)) && (item_r.digit_value < RADIX);

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    scan_nxt    = scan_r;
    lit_seg_nxt = lit_seg_r;
    lit_sel_nxt = lit_sel_r;
    unique case (item_r.opcode)
      OP_SCAN: begin
        if (!enable_r) begin
          lit_seg_nxt = '0;
          lit_sel_nxt = '0;
        end else begin
          lit_seg_nxt = buf_r[scan_r];
          lit_sel_nxt = DIGITS'(1) << scan_r;
          scan_nxt    = (scan_r == PW'(DIGITS - 1)) ? '0 : scan_r + PW'(1);
        end
      end
      OP_SET: begin
        if (set_ok) begin
          buf_nxt[item_r.position[PW-1:0]] = seg_pattern(item_r.digit_value) |
                                             (item_r.decimal_point ? DP_BIT : 8'h00);
        end
      end
      OP_SHOW: begin
        for (int i = 0; i < DIGITS; i++) begin
          buf_nxt[i] = 8'h00;
          if ((DIGITS - 1 - i) < BCD_DIGITS) begin
            if (((DIGITS - 1 - i) == 0) || (num_r >= pow10(DIGITS - 1 - i))) begin
              buf_nxt[i] = seg_pattern(bcd[(DIGITS - 1 - i) % BCD_DIGITS]);
            end
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < DIGITS; i++) begin
          buf_nxt[i] = 8'h00;
        end
      end
      default: begin
        scan_nxt = scan_r;
      end
    endcase
  end

  assign seg_src = enable_r ? lit_seg_nxt : 8'h00;

  for (genvar j = 0; j < DIGIT_PINS; j++) begin : g_pin
    if (j < DIGITS) begin : g_used
      assign dig_lv[j] = dig_pol_r ? (enable_r & lit_sel_nxt[j])
                                   : ~(enable_r & lit_sel_nxt[j]);
    end else begin : g_none
      assign dig_lv[j] = 1'b0;
    end
  end

  always_comb begin
    out_nxt.status         = (item_r.opcode == OP_SET) && !set_ok;
    out_nxt.segment_levels = seg_pol_r ? seg_src : ~seg_src;
    out_nxt.digit_levels   = dig_lv;
  end

  assign out_item = out_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
      num_r  <= sat;
      q1_r   <= prod10[28:19];
      q2_r   <= prod100[25:19];
      q3_r   <= prod1000[26:23];
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_pol_r <= 1'b1;
      dig_pol_r <= 1'b1;
      enable_r  <= 1'b0;
      scan_r    <= '0;
      lit_seg_r <= '0;
      lit_sel_r <= '0;
      for (int i = 0; i < DIGITS; i++) begin
        buf_r[i] <= 8'h00;
      end
    end else begin
      if (cmd.exec) begin
        scan_r    <= scan_nxt;
        lit_seg_r <= lit_seg_nxt;
        lit_sel_r <= lit_sel_nxt;
        for (int i = 0; i < DIGITS; i++) begin
          buf_r[i] <= buf_nxt[i];
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEG_POL: seg_pol_r <= cfg_data;
          CFG_DIG_POL: dig_pol_r <= cfg_data;
          CFG_ENABLE: begin
            enable_r <= cfg_data;
            if (!cfg_data) begin
              lit_seg_r <= '0;
              lit_sel_r <= '0;
            end
          end
          default: enable_r <= enable_r;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/multiplexed_seven_segment_driver.sv
// ----------------------------------------------------------------------------
// Multiplexed seven-segment driver
// Multiplexed display driver: each command transfer returns one result
// transfer with a status bit and the segment and digit pin levels.
// Commands arrive on in_ch: scan tick, set digit, show number, clear buffer.
// Results leave on out_ch and are held until the receiver takes them.
// The user must write polarity and display enable on the cfg_ port only
// while no command is in flight; the block does not enforce this.
// Index 3 is ignored. Each command passes the two-state controller: it is
// accepted, then executed into the output register once that is free.
// The next command is accepted only after this one has executed.
// A new command is taken while an earlier result still waits; if the receiver
// stalls, the execute step holds until the output register is free.
// Reset clears the pattern buffer, the scan position and the lit state,
// sets both polarities active high and disables the display.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_seven_segment_driver #(
  parameter int DIGITS = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  msd_in_if.sink                             in_ch,
  msd_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [msd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic                          cfg_data
);
  import msd_pkg::*;

  cmd_t cmd;

  msd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  msd_datapath #(
    .DIGITS (DIGITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_ch.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_ch.data)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("Command accepted while another was in flight.");

  a_reset_no_result: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("Result valid right after reset.");

  a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> !$past(in_ch.ready))
    else $error("Result appeared without a command in execution.");

endmodule

`default_nettype wire
